### design/tks_pkg.sv
// Shared constants and types of the top-k score selector.
`default_nettype none

package tks_pkg;

   // Number of cells in the chain
   localparam int MAX_KEEP = 16;
   localparam int SCORE_W  = 32;
   localparam int ID_W     = 32;
   localparam int KEEP_W   = 5;
   // Rank counter holds values up to the keep count
   localparam int RANK_W   = $clog2(MAX_KEEP + 1);

   localparam logic signed [SCORE_W-1:0] SCORE_PAD = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic [ID_W-1:0]           ID_PAD    = '0;

   // Request action codes
   localparam logic ACT_OFFER = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   typedef enum logic {
      ST_OFFER,
      ST_DRAIN
   } state_type;

   // One kept candidate as seen by its neighbors
   typedef struct packed {
      logic                      valid;
      logic signed [SCORE_W-1:0] score;
      logic [ID_W-1:0]           id;
   } entry_type;

   // Chain commands from the controller
   typedef struct packed {
      logic insert;
      logic trim;
      logic shift;
   } ctrl_type;

endpackage

`default_nettype wire

### design/tks_cell.sv
// One cell of the sorted insertion chain: holds a single ranked candidate.
`default_nettype none

module tks_cell (
   input  wire                               clock,
   input  wire                               reset,
   input  wire tks_pkg::ctrl_type            ctrl,
   input  wire                               keep_en,
   input  wire signed [tks_pkg::SCORE_W-1:0] new_score,
   input  wire        [tks_pkg::ID_W-1:0]    new_id,
   input  wire tks_pkg::entry_type           prev_entry,
   input  wire                               prev_beat,
   input  wire tks_pkg::entry_type           next_entry,
   output tks_pkg::entry_type                entry,
   output logic                              beat
);

   logic                               valid_ff, valid_in;
   logic signed [tks_pkg::SCORE_W-1:0] score_ff, score_in;
   logic        [tks_pkg::ID_W-1:0]    id_ff, id_in;
   logic                               valid_eff;

   // Entries at or beyond the active keep count do not exist
   assign valid_eff = valid_ff & keep_en;

   // New score goes ahead of this entry when strictly greater, or when this slot is empty
   assign beat = !valid_eff || (new_score > score_ff);

   assign entry.valid = valid_eff;
   assign entry.score = score_ff;
   assign entry.id    = id_ff;

   // Pick next contents: take from above, take the new candidate, pull from below, or hold
   always_comb begin
      valid_in = valid_ff;
      score_in = score_ff;
      id_in    = id_ff;
      if (ctrl.insert) begin
         if (prev_beat) begin
            valid_in = prev_entry.valid & keep_en;
            score_in = prev_entry.score;
            id_in    = prev_entry.id;
         end else if (beat) begin
            valid_in = keep_en;
            score_in = new_score;
            id_in    = new_id;
         end else begin
            valid_in = valid_eff;
         end
      end else if (ctrl.trim) begin
         valid_in = valid_eff;
      end else if (ctrl.shift) begin
         valid_in = next_entry.valid;
         score_in = next_entry.score;
         id_in    = next_entry.id;
      end
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      score_ff <= score_in;
      id_ff    <= id_in;
   end

endmodule

`default_nettype wire

### design/tks_ctrl.sv
// Request/response sequencing and keep count register of the top-k selector.
`default_nettype none

module tks_ctrl (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_wr_en,
   input  wire  [tks_pkg::KEEP_W-1:0]      csr_wr_data,
   input  wire                             req_tvalid,
   input  wire                             req_action,
   output logic                            req_tready,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic                            rsp_tlast,
   output logic [tks_pkg::KEEP_W-1:0]      active_k,
   output tks_pkg::ctrl_type               ctrl
);

   tks_pkg::state_type                state_ff, state_in;
   logic [tks_pkg::KEEP_W-1:0]        keep_count_ff, keep_count_in;
   logic [tks_pkg::RANK_W-1:0]        rank_ff, rank_in;
   logic                              req_fire, rsp_fire, last_rank;

   // Clamp the keep count to 1..MAX_KEEP
   always_comb begin
      if (keep_count_ff == '0) begin
         active_k = tks_pkg::KEEP_W'(1);
      end else if (keep_count_ff > tks_pkg::KEEP_W'(tks_pkg::MAX_KEEP)) begin
         active_k = tks_pkg::KEEP_W'(tks_pkg::MAX_KEEP);
      end else begin
         active_k = keep_count_ff;
      end
   end

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign last_rank = (tks_pkg::KEEP_W'(rank_ff) + tks_pkg::KEEP_W'(1)) == active_k;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tks_pkg::ST_OFFER: begin
            if (req_fire && (req_action == tks_pkg::ACT_DRAIN)) begin
               state_in = tks_pkg::ST_DRAIN;
            end
         end
         tks_pkg::ST_DRAIN: begin
            if (rsp_fire && last_rank) begin
               state_in = tks_pkg::ST_OFFER;
            end
         end
         default: state_in = tks_pkg::ST_OFFER;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      ctrl.insert = 1'b0;
      ctrl.trim   = 1'b0;
      ctrl.shift  = 1'b0;
      case (state_ff)
         tks_pkg::ST_OFFER: begin
            req_tready  = 1'b1;
            ctrl.insert = req_tvalid && (req_action == tks_pkg::ACT_OFFER);
            ctrl.trim   = req_tvalid && (req_action == tks_pkg::ACT_DRAIN);
         end
         tks_pkg::ST_DRAIN: begin
            rsp_tvalid = 1'b1;
            ctrl.shift = rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign rsp_tlast = last_rank;

   // Advance rank on each delivered response, wrap after the last
   always_comb begin
      rank_in = rank_ff;
      if (rsp_fire) begin
         rank_in = last_rank ? '0 : rank_ff + tks_pkg::RANK_W'(1);
      end
   end

   assign keep_count_in = csr_wr_en ? csr_wr_data : keep_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tks_pkg::ST_OFFER;
         rank_ff       <= '0;
         keep_count_ff <= tks_pkg::KEEP_W'(16);
      end else begin
         state_ff      <= state_in;
         rank_ff       <= rank_in;
         keep_count_ff <= keep_count_in;
      end
   end

`ifndef SYNTHESIS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and response sides active together");
   a_drain_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_action == tks_pkg::ACT_DRAIN)) |=> rsp_tvalid)
      else $error("drain request did not start responses");
   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (tks_pkg::KEEP_W'(rank_ff) < active_k))
      else $error("rank beyond keep count");
   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> (req_tready && (rank_ff == '0)))
      else $error("drain did not return to accepting requests");
`endif

endmodule

`default_nettype wire

### design/top_k_score_selector.sv
// Top level of the top-k score selector: controller plus sorted cell chain.
// Offer requests: one per cycle outside a drain; the chain inserts in the same cycle.
// Drain request: k responses follow, the first in the cycle after acceptance, one per
// cycle while rsp_tready is high; requests wait until the last rank is taken.
// Throughput set by the single response port shifting the chain one rank a cycle.
// Reset (synchronous): store empty, keep count 16, ready for requests next cycle.
`default_nettype none

module top_k_score_selector (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_wr_en,
   input  wire  [tks_pkg::KEEP_W-1:0]   csr_wr_data,  // keep_count
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [63:0]                  req_tdata,    // score[31:0], candidate_id[63:32]
   input  wire                          req_tuser,    // action
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [63:0]                  rsp_tdata,    // result_id[31:0], result_score[63:32]
   output logic                         rsp_tuser,    // filled
   output logic                         rsp_tlast     // last
);

   tks_pkg::ctrl_type                 ctrl;
   logic [tks_pkg::KEEP_W-1:0]        active_k;
   logic signed [tks_pkg::SCORE_W-1:0] new_score;
   logic [tks_pkg::ID_W-1:0]          new_id;

   tks_pkg::entry_type entries    [tks_pkg::MAX_KEEP];
   tks_pkg::entry_type prev_chain [tks_pkg::MAX_KEEP];
   tks_pkg::entry_type next_chain [tks_pkg::MAX_KEEP];
   logic               beats      [tks_pkg::MAX_KEEP];
   logic               prev_beats [tks_pkg::MAX_KEEP];
   logic               keep_en    [tks_pkg::MAX_KEEP];

   assign new_score = req_tdata[tks_pkg::SCORE_W-1:0];
   assign new_id    = req_tdata[tks_pkg::SCORE_W +: tks_pkg::ID_W];

   tks_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_action  (req_tuser),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tlast   (rsp_tlast),
      .active_k    (active_k),
      .ctrl        (ctrl)
   );

   // Build the chain: each cell sees its upper and lower neighbor
   for (genvar i = 0; i < tks_pkg::MAX_KEEP; i++) begin : g_cell
      assign keep_en[i] = tks_pkg::KEEP_W'(i) < active_k;

      if (i == 0) begin : g_head
         assign prev_chain[i] = '0;
         assign prev_beats[i] = 1'b0;
      end else begin : g_body
         assign prev_chain[i] = entries[i-1];
         assign prev_beats[i] = beats[i-1];
      end

      if (i == tks_pkg::MAX_KEEP - 1) begin : g_tail
         assign next_chain[i] = '0;
      end else begin : g_link
         assign next_chain[i] = entries[i+1];
      end

      tks_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .keep_en    (keep_en[i]),
         .new_score  (new_score),
         .new_id     (new_id),
         .prev_entry (prev_chain[i]),
         .prev_beat  (prev_beats[i]),
         .next_entry (next_chain[i]),
         .entry      (entries[i]),
         .beat       (beats[i])
      );
   end

   // Present the head cell, padded when empty
   always_comb begin
      rsp_tuser = entries[0].valid;
      if (entries[0].valid) begin
         rsp_tdata = {entries[0].score, entries[0].id};
      end else begin
         rsp_tdata = {tks_pkg::SCORE_PAD, tks_pkg::ID_PAD};
      end
   end

endmodule

`default_nettype wire
